@@ rtl/qse_pkg.sv @@
// Package for the quadrature speed estimator: shared types, codes, reset values
// and the fixed-point rounding and saturation helpers. No dependencies.
package qse_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FACTOR_W = 17;
    localparam int PROD_W = 66;
    localparam int ACC_W = 50;

    // Command codes of an input item.
    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Encoder channel codes.
    localparam logic CH_A = 1'b0;
    localparam logic CH_B = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING      = 2'd2;

    localparam logic [DATA_W-1:0]   RST_SPEED_SCALE    = 32'd49152;
    localparam logic [DATA_W-1:0]   RST_POSITION_SCALE = 32'd536871;
    localparam logic [FACTOR_W-1:0] RST_SMOOTHING      = 17'd9830;
    localparam logic [FACTOR_W-1:0] FULL_WEIGHT        = 17'd65536;

    localparam logic signed [PROD_W-1:0] SAT_MAX  = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN  = -66'sd2147483648;
    localparam logic signed [PROD_W-1:0] HALF_LSB = 66'sd32768;

    typedef struct packed {
        logic [DATA_W-1:0]   speed_scale;
        logic [DATA_W-1:0]   position_scale;
        logic [FACTOR_W-1:0] smoothing_factor;
    } t_cfg;

    // Snapshot that a sample tick hands from the front to the back.
    typedef struct packed {
        logic signed [DATA_W-1:0] count;
        logic signed [DATA_W-1:0] diff;
    } t_sample;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_stat;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_REV,
        BS_RAW,
        BS_RAW_SAT,
        BS_MUL_NEW,
        BS_MUL_OLD,
        BS_SUM,
        BS_FIN
    } t_back_state;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Round half up from Q.32 to Q.16 (floor of value plus one half), then saturate.
    function automatic logic signed [DATA_W-1:0] round_sat16(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] t;
        t = (v + HALF_LSB) >>> 16;
        return sat32(t);
    endfunction

endpackage

@@ rtl/qse_if.sv @@
// Handshake channels of the quadrature speed estimator: input items and results.
// Depends on qse_pkg for the payload widths.
interface qse_in_if;
    logic valid;
    logic ready;
    logic command;
    logic edge_channel;
    logic level_a;
    logic level_b;
    modport source (output valid, command, edge_channel, level_a, level_b, input ready);
    modport sink (input valid, command, edge_channel, level_a, level_b, output ready);
endinterface

interface qse_out_if;
    logic valid;
    logic ready;
    logic signed [qse_pkg::DATA_W-1:0] position_count;
    logic signed [qse_pkg::DATA_W-1:0] revolutions;
    logic signed [qse_pkg::DATA_W-1:0] speed_rpm;
    modport source (output valid, position_count, revolutions, speed_rpm, input ready);
    modport sink (input valid, position_count, revolutions, speed_rpm, output ready);
endinterface

@@ rtl/qse_queue.sv @@
// Short flip-flop queue of sample snapshots between the front and the back.
// Depends on qse_pkg.
module qse_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qse_pkg::t_sample  i_sample,
    input  logic              i_pop,
    output qse_pkg::t_sample  o_sample,
    output qse_pkg::t_q_stat  o_stat
);
    import qse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_sample          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign o_sample     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

endmodule

@@ rtl/qse_front.sv @@
// Front end: accepts items, counts encoder edges and snapshots the count on a
// sample tick. Depends on qse_pkg and qse_if.
module qse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qse_in_if.sink            i_item,
    input  qse_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output qse_pkg::t_sample  o_sample
);
    import qse_pkg::*;

    logic [DATA_W-1:0] r_tick_total, n_tick_total;
    logic [DATA_W-1:0] r_tick_last, n_tick_last;
    logic              accept;
    logic              count_up;

    // Only a sample tick needs queue space, but ready stays free of the payload.
    assign i_item.ready = !i_q_stat.full;
    assign accept       = i_item.valid && i_item.ready;

    // Channel A counts up on unequal levels, channel B on equal levels.
    assign count_up = (i_item.edge_channel == CH_A) ? (i_item.level_a != i_item.level_b)
                                                    : (i_item.level_a == i_item.level_b);

    assign o_push         = accept && (i_item.command == CMD_SAMPLE);
    assign o_sample.count = r_tick_total;
    assign o_sample.diff  = r_tick_total - r_tick_last;

    always_comb begin
        n_tick_total = r_tick_total;
        n_tick_last  = r_tick_last;
        if (accept) begin
            if (i_item.command == CMD_EDGE) begin
                n_tick_total = count_up ? r_tick_total + 1'b1 : r_tick_total - 1'b1;
            end else begin
                n_tick_last = r_tick_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_total <= '0;
            r_tick_last  <= '0;
        end else begin
            r_tick_total <= n_tick_total;
            r_tick_last  <= n_tick_last;
        end
    end

endmodule

@@ rtl/qse_back.sv @@
// Back end: sequencer around one shared 33x33 signed multiplier that turns a
// sample snapshot into revolutions and filtered speed. Depends on qse_pkg, qse_if.
module qse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qse_pkg::t_cfg       i_cfg,
    input  qse_pkg::t_q_stat    i_q_stat,
    input  qse_pkg::t_sample    i_sample,
    output qse_pkg::t_back_stat o_stat,
    qse_out_if.source           o_result
);
    import qse_pkg::*;

    t_back_state r_state, n_state;

    logic signed [DATA_W:0]   op_a, op_b;
    logic signed [PROD_W-1:0] n_prod, r_prod;
    logic signed [DATA_W-1:0] r_count, r_diff, r_revs, r_raw, r_smooth;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] filt;
    logic [FACTOR_W-1:0]      factor, factor_rest;
    logic                     out_free;
    logic                     pop, load_revs, load_raw, load_acc, add_acc, finish;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_count, r_out_revs, r_out_speed;

    assign factor      = (i_cfg.smoothing_factor > FULL_WEIGHT) ? FULL_WEIGHT
                                                                : i_cfg.smoothing_factor;
    assign factor_rest = FULL_WEIGHT - factor;
    assign out_free    = !r_out_valid || o_result.ready;
    assign n_prod      = op_a * op_b;
    assign filt        = round_sat16(PROD_W'(r_acc));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:    if (!i_q_stat.empty) n_state = BS_REV;
            BS_REV:     n_state = BS_RAW;
            BS_RAW:     n_state = BS_RAW_SAT;
            BS_RAW_SAT: n_state = BS_MUL_NEW;
            BS_MUL_NEW: n_state = BS_MUL_OLD;
            BS_MUL_OLD: n_state = BS_SUM;
            BS_SUM:     n_state = BS_FIN;
            BS_FIN:     if (out_free) n_state = BS_IDLE;
            default:    n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        op_a      = '0;
        op_b      = '0;
        pop       = 1'b0;
        load_revs = 1'b0;
        load_raw  = 1'b0;
        load_acc  = 1'b0;
        add_acc   = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                pop = !i_q_stat.empty;
            end
            BS_REV: begin
                op_a = DATA_W'(0) + $signed({r_count[DATA_W-1], r_count});
                op_b = $signed({1'b0, i_cfg.position_scale});
            end
            BS_RAW: begin
                load_revs = 1'b1;
                op_a = $signed({r_diff[DATA_W-1], r_diff});
                op_b = $signed({1'b0, i_cfg.speed_scale});
            end
            BS_RAW_SAT: begin
                load_raw = 1'b1;
            end
            BS_MUL_NEW: begin
                op_a = $signed({r_raw[DATA_W-1], r_raw});
                op_b = $signed({(DATA_W + 1 - FACTOR_W)'(0), factor});
            end
            BS_MUL_OLD: begin
                load_acc = 1'b1;
                op_a = $signed({r_smooth[DATA_W-1], r_smooth});
                op_b = $signed({(DATA_W + 1 - FACTOR_W)'(0), factor_rest});
            end
            BS_SUM: begin
                add_acc = 1'b1;
            end
            BS_FIN: begin
                finish = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_stat.busy = (r_state != BS_IDLE);
    assign o_stat.pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_smooth    <= filt;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (pop) begin
            r_count <= i_sample.count;
            r_diff  <= i_sample.diff;
        end
        if (load_revs) begin
            r_revs <= round_sat16(r_prod);
        end
        if (load_raw) begin
            r_raw <= sat32(r_prod);
        end
        if (load_acc) begin
            r_acc <= $signed(r_prod[ACC_W-1:0]);
        end else if (add_acc) begin
            r_acc <= r_acc + $signed(r_prod[ACC_W-1:0]);
        end
        if (finish) begin
            r_out_count <= r_count;
            r_out_revs  <= r_revs;
            r_out_speed <= filt;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.position_count = r_out_count;
    assign o_result.revolutions    = r_out_revs;
    assign o_result.speed_rpm      = r_out_speed;

endmodule

@@ rtl/quadrature_speed_estimator.sv @@
// Top level of the quadrature speed estimator: configuration registers, front,
// sample queue and back. Depends on qse_pkg, qse_if, qse_front, qse_queue, qse_back.
//
// Usage. Items arrive on i_item (valid/ready). An item with command set to edge
// names the encoder channel that moved and both levels after the edge; it updates
// the signed tick counter and produces no result. An item with command set to
// sample produces exactly one result on o_result: the tick count, the output
// shaft revolutions (Q16.16) and the low-pass filtered speed in RPM (Q16.16).
//
// Throughput. Edge items are taken one per cycle whenever the sample queue has
// room. The back end works one sample at a time, stepping its sequencer
// around one shared multiplier (position, raw speed and two filter products).
// The queue holds QUEUE_DEPTH samples, so ready drops only when that many sample
// ticks wait; edges keep being counted while the back end computes.
// Path. An accepted sample is registered in the queue, popped by the idle back end,
// stepped through REV, RAW, RAW_SAT, MUL_NEW, MUL_OLD and SUM, then output in FIN.
// Stalls. A result holds in the output register until taken; while it waits the
// back end stops in its final step and the queue, then i_item.ready, back up.
// Reset. i_rst_n low clears the counters, the filter state, the queue and the
// output valid, and loads the configuration reset values. Configuration is
// written through i_cfg_we, i_cfg_index and i_cfg_data; unknown indexes are ignored.
module quadrature_speed_estimator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    qse_in_if.sink                            i_item,
    qse_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [qse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qse_pkg::DATA_W-1:0]        i_cfg_data
);
    import qse_pkg::*;

    t_cfg       r_cfg;
    t_q_stat    q_stat;
    t_back_stat back_stat;
    t_sample    push_sample, head_sample;
    logic       push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale      <= RST_SPEED_SCALE;
            r_cfg.position_scale   <= RST_POSITION_SCALE;
            r_cfg.smoothing_factor <= RST_SMOOTHING;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED_SCALE:    r_cfg.speed_scale      <= i_cfg_data;
                CFG_POSITION_SCALE: r_cfg.position_scale   <= i_cfg_data;
                CFG_SMOOTHING:      r_cfg.smoothing_factor <= i_cfg_data[FACTOR_W-1:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    qse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_sample (push_sample)
    );

    qse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (push_sample),
        .i_pop    (back_stat.pop),
        .o_sample (head_sample),
        .o_stat   (q_stat)
    );

    qse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_sample (head_sample),
        .o_stat   (back_stat),
        .o_result (o_result)
    );

    // An accepted sample tick is waiting in the queue on the following cycle.
    a_sample_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && (i_item.command == CMD_SAMPLE)) |=> !q_stat.empty)
        else $error("accepted sample tick did not reach the queue");

    // A new result only appears out of a running computation.
    a_result_from_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(back_stat.busy))
        else $error("result appeared without a computation");

    // The back end never takes a snapshot from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pop |-> (!q_stat.empty && !back_stat.busy))
        else $error("back end popped an empty queue or while busy");

endmodule
